// ===== src/esau_pkg.sv =====
// Shared types and constants of the extended stochastic arithmetic unit.
// Holds the LFSR step function, operation codes and the sequencer state type.
// No dependencies.
package esau_pkg;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'hACE1;

  // operation codes of the action field
  localparam logic ACT_MUL = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // one step of the right-shifting Galois LFSR
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

// ===== src/extended_stochastic_arith_unit.sv =====
// Extended stochastic multiply / add unit, bit-serial over the stream positions.
// One stream position per cycle while running, held at the last position while the
// previous result sits unclaimed; a new item is taken only once the unit is back idle.
// The single LFSR steps four (multiply) or six (add) draws per stream position.
// Reset: asynchronous active low; the LFSR returns to 0xACE1, the unit goes idle
// and no result is held.  Depends on esau_pkg.
module extended_stochastic_arith_unit #(
  parameter int STREAM_LENGTH = 512,
  parameter int FRACTION_BITS = 6,
  parameter int INTEGER_BITS  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: LFSR seed
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic signed [8:0] operand_a_i,
  input  logic signed [8:0] operand_b_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [9:0]        numerator_ones_o,
  output logic [9:0]        denominator_ones_o,
  output logic signed [9:0] result_value_o
);
  import esau_pkg::*;

  // draw width: F+I+1 bits of the LFSR, capped at the full 16-bit state
  localparam int DW = (FRACTION_BITS + INTEGER_BITS + 1 > 16) ? 16
                    : FRACTION_BITS + INTEGER_BITS + 1;
  // compare width: holds any draw and any signed threshold
  localparam int CW = (FRACTION_BITS + INTEGER_BITS + 2 > 17) ?
                      FRACTION_BITS + INTEGER_BITS + 2 : 17;
  localparam int PW = $clog2(STREAM_LENGTH);

  localparam logic [15:0]   DRAW_MASK = 16'((32'd1 << DW) - 32'd1);
  localparam logic [CW-1:0] OFFSET_C  = {{(CW-1){1'b0}}, 1'b1} << (FRACTION_BITS + INTEGER_BITS);
  localparam logic [CW-1:0] ONE_C     = {{(CW-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic [CW-1:0] TY_C      = OFFSET_C + ONE_C;
  localparam logic [9:0]    OFFSET_10 = OFFSET_C[9:0];
  localparam logic [PW-1:0] LAST_POS  = PW'(STREAM_LENGTH - 1);

  state_e        state_q, state_d;
  logic [15:0]   lfsr_q, lfsr_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [9:0]    num_q, num_d;
  logic [9:0]    den_q, den_d;
  logic          add_q;
  logic [CW-1:0] ta_q, tb_q;
  logic          out_valid_q, out_valid_d;
  logic [9:0]    out_num_q, out_den_q, out_res_q;

  logic          in_take, out_take, last, advance;
  logic [15:0]   s1, s2, s3, s4, s5, s6;
  logic          ax, ay, bx, by, rx, ry;
  logic [9:0]    num_next, den_next;

  // a new item is taken only while idle; a waiting result does not block it
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign last       = (pos_q == LAST_POS);
  // hold the final position while the previous result still sits unclaimed
  assign advance    = (state_q == ST_RUN) && !(last && out_valid_q && out_stall_i);

  // draw chain for one stream position: aX, aY, bX, bY, select, parity
  always_comb begin
    s1 = lfsr_step(lfsr_q);
    s2 = lfsr_step(s1);
    s3 = lfsr_step(s2);
    s4 = lfsr_step(s3);
    s5 = lfsr_step(s4);
    s6 = lfsr_step(s5);
  end

  function automatic logic below(input logic [15:0] s, input logic [CW-1:0] thr);
    logic [CW-1:0] d;
    d = {{(CW-16){1'b0}}, s & DRAW_MASK};
    return $signed(d) < $signed(thr);
  endfunction

  always_comb begin
    ax = below(s1, ta_q);
    ay = below(s2, TY_C);
    bx = below(s3, tb_q);
    by = below(s4, TY_C);
    unique case (add_q)
      ACT_ADD: begin
        rx = s5[0] ? (ay == bx) : (ax == by);
        ry = ~(s6[0] ^ ay ^ by);
      end
      default: begin
        rx = (ax == bx);
        ry = (ay == by);
      end
    endcase
    num_next = num_q + {9'd0, rx};
    den_next = den_q + {9'd0, ry};
  end

  always_comb begin
    state_d     = state_q;
    lfsr_d      = lfsr_q;
    pos_d       = pos_q;
    num_d       = num_q;
    den_d       = den_q;
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_RUN;
          pos_d   = '0;
          num_d   = '0;
          den_d   = '0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          // advance the LFSR by the draws this position used
          lfsr_d = (add_q == ACT_ADD) ? s6 : s4;
          num_d  = num_next;
          den_d  = den_next;
          pos_d  = pos_q + PW'(1);
          if (last) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // the user must write the seed only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      lfsr_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lfsr_q      <= SEED_RESET;
      pos_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      pos_q       <= pos_d;
      num_q       <= num_d;
      den_q       <= den_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operand thresholds: operand + 2^(F+I), sign-extended to the compare width
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      add_q <= action_i;
      ta_q  <= {{(CW-9){operand_a_i[8]}}, operand_a_i} + OFFSET_C;
      tb_q  <= {{(CW-9){operand_b_i[8]}}, operand_b_i} + OFFSET_C;
    end
  end

  // result register: drop the counts in at the last position
  always_ff @(posedge clk_i) begin
    if (advance && last) begin
      out_num_q <= num_next;
      out_den_q <= den_next;
      out_res_q <= num_next - OFFSET_10;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign numerator_ones_o   = out_num_q;
  assign denominator_ones_o = out_den_q;
  assign result_value_o     = $signed(out_res_q);

endmodule

// ===== bench/extended_stochastic_arith_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the extended stochastic multiply / add unit.
// Predicts the stream counts with its own LFSR copy and scores each result in order.
// Depends on esau_pkg and extended_stochastic_arith_unit.
module extended_stochastic_arith_unit_tb;
  import esau_pkg::*;

  localparam int STREAM_LEN  = 512;
  localparam int FRAC_BITS   = 6;
  localparam int INT_BITS    = 2;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 2500;
  localparam int SETTLE      = 600;
  localparam int RANDOM_ITEMS_PER_PHASE = 383;

  // Scoreboard: mirrors the random source, predicts the counts of each
  // accepted transaction and checks results in arrival order.
  class esau_count_board;
    typedef struct {
      logic [9:0] num_ones;
      logic [9:0] den_ones;
      logic [9:0] value;
    } counts_t;

    logic [15:0] lfsr;
    counts_t     expected_counts[$];
    int          errors;

    function new();
      lfsr   = SEED_RESET;
      errors = 0;
    endfunction

    function void load_seed(logic [15:0] seed);
      lfsr = seed;
    endfunction

    // Advance the Galois register once, then hand back its low draw bits.
    function int next_draw();
      lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
      return int'(lfsr[FRAC_BITS+INT_BITS:0]);
    endfunction

    function void note_operands(logic act, logic signed [8:0] a, logic signed [8:0] b);
      int      thr_a;
      int      thr_b;
      int      thr_den;
      int      num_cnt;
      int      den_cnt;
      bit      ax, ay, bx, by, sel, par, rx, ry;
      counts_t c;
      thr_a   = int'(a) + (1 << (FRAC_BITS + INT_BITS));
      thr_b   = int'(b) + (1 << (FRAC_BITS + INT_BITS));
      thr_den = (1 << FRAC_BITS) + (1 << (FRAC_BITS + INT_BITS));
      num_cnt = 0;
      den_cnt = 0;
      for (int pos = 0; pos < STREAM_LEN; pos++) begin
        // fixed draw order: a numerator, a denominator, b numerator, b denominator
        ax = next_draw() < thr_a;
        ay = next_draw() < thr_den;
        bx = next_draw() < thr_b;
        by = next_draw() < thr_den;
        if (act == ACT_ADD) begin
          sel = next_draw() & 1;
          par = next_draw() & 1;
          rx  = sel ? (ay == bx) : (ax == by);
          ry  = ((par + ay + by) % 2) == 0;
        end else begin
          rx = (ax == bx);
          ry = (ay == by);
        end
        num_cnt += rx;
        den_cnt += ry;
      end
      c.num_ones = num_cnt[9:0];
      c.den_ones = den_cnt[9:0];
      c.value    = 10'(num_cnt - (1 << (FRAC_BITS + INT_BITS)));
      expected_counts.push_back(c);
    endfunction

    function void check_counts(logic [9:0] num, logic [9:0] den, logic [9:0] value);
      counts_t c;
      if (expected_counts.size() == 0) begin
        $error("unexpected result: numerator_ones %0d denominator_ones %0d", num, den);
        errors++;
        return;
      end
      c = expected_counts.pop_front();
      if (num !== c.num_ones) begin
        $error("numerator_ones expected %0d actual %0d", c.num_ones, num);
        errors++;
      end
      if (den !== c.den_ones) begin
        $error("denominator_ones expected %0d actual %0d", c.den_ones, den);
        errors++;
      end
      if (value !== c.value) begin
        $error("result_value expected %0d actual %0d",
               $signed(c.value), $signed(value));
        errors++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [15:0]       cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              action      = ACT_MUL;
  logic signed [8:0] operand_a   = '0;
  logic signed [8:0] operand_b   = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [9:0]        numerator_ones;
  logic [9:0]        denominator_ones;
  logic signed [9:0] result_value;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;
  int cycle_count   = 0;

  esau_count_board sb = new();

  extended_stochastic_arith_unit #(
    .STREAM_LENGTH(STREAM_LEN),
    .FRACTION_BITS(FRAC_BITS),
    .INTEGER_BITS (INT_BITS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .operand_a_i       (operand_a),
    .operand_b_i       (operand_b),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .numerator_ones_o  (numerator_ones),
    .denominator_ones_o(denominator_ones),
    .result_value_o    (result_value)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard the run: a stuck handshake ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL extended_stochastic_arith_unit");
      $finish;
    end
  end

  // Result side: score the transaction accepted at this edge, then pick the
  // stall for the next cycle. A long hold request is counted down here so
  // the unit backs up and stalls its input while the sender keeps offering.
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      sb.check_counts(numerator_ones, denominator_ones, result_value);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one transaction and hold it until the unit takes it. Valid is left
  // high on return; the next call or a pause decides whether it drops.
  task automatic send_item(input logic act, input logic signed [8:0] a,
                           input logic signed [8:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      operand_a <= 9'($urandom);
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_operands(act, a, b);
  endtask

  // Drop valid and wait until every predicted result has been scored.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Reseed only while the unit sits idle.
  task automatic write_seed(input logic [15:0] seed);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.load_seed(seed);
  endtask

  // Mostly uniform operands, with a share of the corners mixed in.
  function automatic logic signed [8:0] pick_operand();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(5))
        0:       return -9'sd256;
        1:       return 9'sd255;
        2:       return 9'sd0;
        3:       return -9'sd1;
        4:       return 9'sd64;
        default: return -9'sd64;
      endcase
    end
    return 9'($urandom_range(511));
  endfunction

  task automatic run_random_phase(input int snd_pct, input int rcv_pct, input int phase);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
      // back the unit up once, and let the sender run dry once
      if (phase == 0 && n == 40) hold_request = 1'b1;
      if (phase == 1 && n == 100) drain_results();
      send_item(logic'($urandom_range(1)), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: operand corners for both operations from the reset seed.
    // An operand of -256 gives a zero threshold, so its numerator bits never fire.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_item(ACT_MUL, 9'sd0, 9'sd0);
    send_item(ACT_MUL, 9'sd255, 9'sd255);
    send_item(ACT_MUL, -9'sd256, -9'sd256);
    send_item(ACT_MUL, -9'sd256, 9'sd255);
    send_item(ACT_MUL, 9'sd64, -9'sd64);
    send_item(ACT_ADD, 9'sd255, 9'sd255);
    send_item(ACT_ADD, -9'sd256, -9'sd256);
    send_item(ACT_ADD, 9'sd0, 9'sd0);
    send_item(ACT_ADD, 9'sd255, -9'sd256);
    send_item(ACT_ADD, -9'sd1, 9'sd1);

    // Seed extremes: all ones, a single one, and all zeros, where the
    // register sticks at zero and every draw is zero.
    write_seed(16'hFFFF);
    send_item(ACT_MUL, 9'sd85, -9'sd86);
    send_item(ACT_ADD, -9'sd171, 9'sd170);
    write_seed(16'h0001);
    send_item(ACT_ADD, 9'sd32, 9'sd100);
    send_item(ACT_MUL, -9'sd128, 9'sd127);
    write_seed(16'h0000);
    send_item(ACT_MUL, 9'sd10, -9'sd20);
    send_item(ACT_ADD, -9'sd256, 9'sd255);
    send_item(ACT_MUL, -9'sd256, -9'sd256);

    // Random phases: slow receiver, then slow sender, then full rate.
    write_seed(16'($urandom_range(65535, 1)));
    run_random_phase(7, 71, 0);
    write_seed(16'($urandom_range(65535, 1)));
    run_random_phase(71, 7, 1);
    write_seed(16'($urandom_range(65535, 1)));
    run_random_phase(0, 0, 2);

    drain_results();
    repeat (SETTLE) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS extended_stochastic_arith_unit");
    end else begin
      $display("FAIL extended_stochastic_arith_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/esau_pkg.sv
src/extended_stochastic_arith_unit.sv
bench/extended_stochastic_arith_unit_tb.sv
